>>> rtl/ntds_pkg.sv
package ntds_pkg;

	// Sequencer phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_INTRO = 3'd1;
	localparam logic [2:0] PH_SHOW  = 3'd2;
	localparam logic [2:0] PH_PAUSE = 3'd3;

	// Item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_SECOND = 2'd1;
	localparam logic [1:0] KIND_RESYNC = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_INTRO_FRAME_MS = 3'd0;
	localparam logic [2:0] REG_DIGIT_MS       = 3'd1;
	localparam logic [2:0] REG_PAUSE_MS       = 3'd2;
	localparam logic [2:0] REG_PAUSE_REPEATS  = 3'd3;
	localparam logic [2:0] REG_SECS_PER_TRIG  = 3'd4;

	localparam int PERIOD_W = 11;
	localparam int CFG_IDX_W = 3;

	// Reset values of the registers
	localparam logic [PERIOD_W-1:0] INTRO_FRAME_MS_RST = 11'd60;
	localparam logic [PERIOD_W-1:0] DIGIT_MS_RST       = 11'd250;
	localparam logic [PERIOD_W-1:0] PAUSE_MS_RST       = 11'd1000;
	localparam logic [1:0]          PAUSE_REPEATS_RST  = 2'd2;
	localparam logic [5:0]          SECS_PER_TRIG_RST  = 6'd60;

	localparam logic [3:0] DIGIT_BLANK = 4'd10;
	localparam logic [3:0] LAST_INTRO  = 4'd9;
	localparam logic [5:0] SECOND_MAX  = 6'd63;

	typedef logic [3:0] digit_t;

	// Tens digit of a value below 64, by comparison
	function automatic digit_t tens_of(input logic [5:0] v);
		digit_t t;
		if (v >= 6'd60) t = 4'd6;
		else if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else t = 4'd0;
		return t;
	endfunction

	// Units digit: subtract ten times the tens digit
	function automatic digit_t units_of(input logic [5:0] v);
		logic [5:0] tens_x10;
		logic [5:0] rem;
		tens_x10 = {2'b00, tens_of(v)} * 6'd10;
		rem = v - tens_x10;
		return rem[3:0];
	endfunction

endpackage

>>> rtl/nixie_time_display_sequencer_top.sv
// The result of an accepted item beat is registered and valid in the next cycle.
// Throughput: one item per cycle while results are taken; the result register frees
// as it is taken, so a new item is accepted while the previous result waits only if taken.
// Reset (arst_n low, asynchronous): counters cleared, phase idle, shown digit blank,
// registers at their default values, no result pending.
module nixie_time_display_sequencer_top #(
	parameter int TICK_COUNT_WIDTH = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [ntds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ntds_pkg::PERIOD_W-1:0]  cfg_data,
	// item channel
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [1:0]                     kind,
	input  logic [4:0]                     hour,
	input  logic [5:0]                     minute,
	input  logic [5:0]                     second,
	// result channel
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [3:0]                     digit,
	output logic                           digit_write,
	output logic                           force_solid,
	output logic                           busy_res
);
	import ntds_pkg::*;

	localparam int CMP_W = (TICK_COUNT_WIDTH > PERIOD_W) ? TICK_COUNT_WIDTH : PERIOD_W;
	localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

	// Configuration registers
	logic [PERIOD_W-1:0] intro_frame_ms_q, digit_ms_q, pause_ms_q;
	logic [1:0]          pause_repeats_q;
	logic [5:0]          secs_per_trig_q;

	// Sequencer state
	logic [TICK_COUNT_WIDTH-1:0] ms_count_q;
	logic [5:0]                  second_count_q;
	logic [2:0]                  phase_q;
	logic [3:0]                  frame_index_q;
	logic [1:0]                  repeat_count_q;
	logic [4:0]                  hour_latch_q;
	logic [5:0]                  minute_latch_q;
	digit_t                      shown_digit_q;

	// Next-state values
	logic [TICK_COUNT_WIDTH-1:0] ms_count_d, ms_upd;
	logic [5:0]                  second_count_d, sec_upd;
	logic [2:0]                  phase_d;
	logic [3:0]                  frame_index_d;
	logic [1:0]                  repeat_count_d;
	logic [4:0]                  hour_latch_d;
	logic [5:0]                  minute_latch_d;
	digit_t                      shown_digit_d;
	logic                        wrote;

	logic [CMP_W-1:0] ms_ext;
	logic             intro_due, digit_due, pause_due;

	logic res_valid_q;
	logic accept;

	assign item_ready = !res_valid_q || res_ready;
	assign accept     = item_valid && item_ready;
	assign res_valid  = res_valid_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intro_frame_ms_q <= INTRO_FRAME_MS_RST;
			digit_ms_q       <= DIGIT_MS_RST;
			pause_ms_q       <= PAUSE_MS_RST;
			pause_repeats_q  <= PAUSE_REPEATS_RST;
			secs_per_trig_q  <= SECS_PER_TRIG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTRO_FRAME_MS: intro_frame_ms_q <= cfg_data;
				REG_DIGIT_MS:       digit_ms_q       <= cfg_data;
				REG_PAUSE_MS:       pause_ms_q       <= cfg_data;
				REG_PAUSE_REPEATS:  pause_repeats_q  <= cfg_data[1:0];
				REG_SECS_PER_TRIG:  secs_per_trig_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Advance the tick and second counters (saturating), or load the second counter on a resync
	always_comb begin
		ms_upd  = ms_count_q;
		sec_upd = second_count_q;
		unique case (kind)
			KIND_TICK:   if (ms_count_q != TICK_MAX) ms_upd = ms_count_q + 1'b1;
			KIND_SECOND: if (second_count_q != SECOND_MAX) sec_upd = second_count_q + 1'b1;
			KIND_RESYNC: sec_upd = second;
			default: ;
		endcase
	end

	assign ms_ext    = CMP_W'(ms_upd);
	assign intro_due = ms_ext >= CMP_W'(intro_frame_ms_q);
	assign digit_due = ms_ext >= CMP_W'(digit_ms_q);
	assign pause_due = ms_ext >= CMP_W'(pause_ms_q);

	// Trigger test, then one step of the phase machine
	always_comb begin
		ms_count_d     = ms_upd;
		second_count_d = sec_upd;
		phase_d        = phase_q;
		frame_index_d  = frame_index_q;
		repeat_count_d = repeat_count_q;
		hour_latch_d   = hour_latch_q;
		minute_latch_d = minute_latch_q;
		shown_digit_d  = shown_digit_q;
		wrote          = 1'b0;
		if (sec_upd >= secs_per_trig_q) begin
			second_count_d = '0;
			hour_latch_d   = hour;
			minute_latch_d = minute;
			frame_index_d  = '0;
			repeat_count_d = '0;
			phase_d        = PH_INTRO;
		end else begin
			unique case (phase_q)
				PH_INTRO: begin
					if (intro_due) begin
						ms_count_d = '0;
						wrote      = 1'b1;
						if (frame_index_q > LAST_INTRO) begin
							frame_index_d = '0;
							shown_digit_d = DIGIT_BLANK;
							phase_d       = PH_SHOW;
						end else begin
							shown_digit_d = frame_index_q;
							frame_index_d = frame_index_q + 1'b1;
						end
					end
				end
				PH_SHOW: begin
					if (digit_due) begin
						ms_count_d    = '0;
						wrote         = 1'b1;
						frame_index_d = frame_index_q + 1'b1;
						unique case (frame_index_q)
							4'd0: shown_digit_d = tens_of({1'b0, hour_latch_q});
							4'd2: shown_digit_d = units_of({1'b0, hour_latch_q});
							4'd4: shown_digit_d = tens_of(minute_latch_q);
							4'd6: shown_digit_d = units_of(minute_latch_q);
							4'd1, 4'd3, 4'd5: shown_digit_d = DIGIT_BLANK;
							default: begin
								shown_digit_d = DIGIT_BLANK;
								frame_index_d = '0;
								phase_d       = PH_PAUSE;
							end
						endcase
					end
				end
				PH_PAUSE: begin
					if (repeat_count_q >= pause_repeats_q) begin
						frame_index_d  = '0;
						repeat_count_d = '0;
						phase_d        = PH_IDLE;
					end else if (pause_due) begin
						ms_count_d     = '0;
						repeat_count_d = repeat_count_q + 1'b1;
						phase_d        = PH_SHOW;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Hold sequencer state, update on each accepted item beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_count_q     <= '0;
			second_count_q <= '0;
			phase_q        <= PH_IDLE;
			frame_index_q  <= '0;
			repeat_count_q <= '0;
			hour_latch_q   <= '0;
			minute_latch_q <= '0;
			shown_digit_q  <= DIGIT_BLANK;
		end else if (accept) begin
			ms_count_q     <= ms_count_d;
			second_count_q <= second_count_d;
			phase_q        <= phase_d;
			frame_index_q  <= frame_index_d;
			repeat_count_q <= repeat_count_d;
			hour_latch_q   <= hour_latch_d;
			minute_latch_q <= minute_latch_d;
			shown_digit_q  <= shown_digit_d;
		end
	end

	// Result valid: set on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			digit       <= shown_digit_d;
			digit_write <= wrote;
			force_solid <= (phase_d != PH_IDLE);
			busy_res    <= (phase_d != PH_IDLE);
		end
	end

endmodule
